// ----- src/mmrt_pkg.sv -----
// Shared types and constants for the memory-map region table.
// Used by mmrt_cell and memory_map_region_table; no dependencies.
package mmrt_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int PAGE_SHIFT_DEF  = 12;

    localparam logic [31:0] TYPE_RAM      = 32'd1;
    localparam logic [31:0] TYPE_RESERVED = 32'd2;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_CARVE = 2'd1,
        K_FIND  = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SORT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic mode_find;
        logic apply;
        logic load;
        logic sort_en;
        logic parity;
    } t_cell_ctl;

endpackage

// ----- src/mmrt_cell.sv -----
// One table entry of the region table chain, with its search carry stage.
// Depends on mmrt_pkg; instantiated in a row by memory_map_region_table.
module mmrt_cell import mmrt_pkg::*; #(
    parameter int IDX        = 0,
    parameter int CW         = 6,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [CW-1:0] i_count,
    input  logic [63:0]   i_sp,
    input  logic [63:0]   i_ep,
    input  logic [63:0]   i_lo,
    input  logic [63:0]   i_rlo,
    input  logic [63:0]   i_rhi,
    input  logic [63:0]   i_lo_rsz,
    input  logic [31:0]   i_rsz,
    input  logic [63:0]   i_ld_base,
    input  logic [63:0]   i_ld_len,
    input  logic [31:0]   i_ld_type,
    input  logic [63:0]   i_up_base,
    input  logic [63:0]   i_up_len,
    input  logic [31:0]   i_up_type,
    input  logic [63:0]   i_dn_base,
    input  logic [63:0]   i_dn_len,
    input  logic [31:0]   i_dn_type,
    input  logic          i_dn_swap,
    input  logic          i_dn_cv,
    input  logic [63:0]   i_dn_cval,
    output logic [63:0]   o_base,
    output logic [63:0]   o_len,
    output logic [31:0]   o_type,
    output logic          o_swap,
    output logic          o_cv,
    output logic [63:0]   o_cval
);

    localparam logic [63:0]   PMASK  = (64'd1 << PAGE_SHIFT) - 64'd1;
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [CW:0]   UP_IDX = (CW+1)'(IDX + 1);
    localparam logic          PAR    = ((IDX % 2) == 1);

    logic [63:0] r_base, r_len, n_base, n_len;
    logic [31:0] r_type, n_type;
    logic [63:0] r_s, r_ee;
    logic        r_hit;
    logic [63:0] r_hval;
    logic        r_cv;
    logic [63:0] r_cval;

    logic        live, up_live, swap_up;
    logic [63:0] e, span, top, rsz64, faddr;
    logic        fhit, touch, split;

    assign live    = MY_IDX < i_count;
    assign up_live = UP_IDX < {1'b0, i_count};
    assign rsz64   = {32'd0, i_rsz};

    always_comb begin
        e     = r_ee & ~PMASK;
        span  = (e > r_s) ? (e - r_s) : 64'd0;
        top   = (e < i_rhi) ? e : i_rhi;
        faddr = (e > i_rhi) ? (i_rhi - rsz64) : (e - rsz64);
        fhit  = live && (r_type == TYPE_RAM) && (span >= rsz64) && (e > i_rlo)
                && (r_s < i_rhi)
                && (((r_s >= i_lo) && (r_s + rsz64 <= top))
                    || ((r_s < i_lo) && (i_lo_rsz <= top)));
        touch = live && (r_type == TYPE_RAM) && (r_ee > i_sp) && (r_base < i_ep);
        split = touch && (r_base < i_sp) && (r_ee > i_ep);
    end

    assign swap_up = i_ctl.sort_en && (PAR == i_ctl.parity) && up_live
                     && (r_base > i_up_base);

    always_comb begin
        n_base = r_base;
        n_len  = r_len;
        n_type = r_type;
        priority if (i_ctl.apply && touch) begin
            priority if (r_base < i_sp) begin
                n_len = i_sp - r_base;
            end else if (r_ee <= i_ep) begin
                n_type = TYPE_RESERVED;
            end else begin
                n_base = i_ep;
                n_len  = r_ee - i_ep;
            end
        end else if (i_ctl.load && (i_count == MY_IDX)) begin
            n_base = i_ld_base;
            n_len  = i_ld_len;
            n_type = i_ld_type;
        end else if (swap_up) begin
            n_base = i_up_base;
            n_len  = i_up_len;
            n_type = i_up_type;
        end else if (i_dn_swap) begin
            n_base = i_dn_base;
            n_len  = i_dn_len;
            n_type = i_dn_type;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_len  <= n_len;
        r_type <= n_type;
        r_s    <= (r_base + PMASK) & ~PMASK;
        r_ee   <= r_base + r_len;
        r_hval <= i_ctl.mode_find ? faddr : r_ee;
        r_cval <= r_hit ? r_hval : i_dn_cval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_cv  <= 1'b0;
        end else begin
            r_hit <= i_ctl.mode_find ? fhit : split;
            r_cv  <= r_hit | i_dn_cv;
        end
    end

    assign o_base = r_base;
    assign o_len  = r_len;
    assign o_type = r_type;
    assign o_swap = swap_up;
    assign o_cv   = r_cv;
    assign o_cval = r_cval;

endmodule

// ----- src/memory_map_region_table.sv -----
// Top level of the memory-map region table: control sequencer and the cell row.
// Depends on mmrt_pkg and mmrt_cell.

// One request at a time. Clear goes straight to the result; add loads the
// entry, then one odd-even transposition round per cycle across the cell
// row; find runs a carry scan in which a hit carry ripples one cell per cycle
// from the lowest entry to the highest; carve runs that carry scan, a single
// update step of all cells, then the sort rounds. A full table turns an
// add or a splitting carve into status 1 with the table unchanged. A new
// request is taken while a previous result still waits on the output.
module memory_map_region_table import mmrt_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_entry_base,
    input  logic [63:0] i_entry_length,
    input  logic [31:0] i_entry_type,
    input  logic [63:0] i_range_start,
    input  logic [63:0] i_range_end,
    input  logic [31:0] i_request_size,
    input  logic [63:0] i_window_low,
    input  logic [63:0] i_window_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_found_addr,
    output logic        o_found,
    output logic [5:0]  o_entry_total,
    output logic        o_status
);

    localparam int          CW    = $clog2(MAX_ENTRIES + 1);
    localparam int          SW    = $clog2(MAX_ENTRIES + 5);
    localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    t_state        r_state, n_state;
    logic [SW-1:0] r_step, n_step;
    logic [CW-1:0] r_count, n_count;
    t_kind         r_kind;
    logic [63:0]   r_sp, r_ep, r_lo, r_rlo, r_rhi, r_lo_rsz;
    logic [31:0]   r_rsz;
    logic [63:0]   r_ldb, r_ldl;
    logic [31:0]   r_ldt;
    logic [63:0]   r_res_addr, n_res_addr;
    logic          r_res_found, n_res_found, r_res_status, n_res_status;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_addr;
    logic          r_out_found, r_out_status;
    logic [5:0]    r_out_total;

    logic          accept, full, out_free;
    t_cell_ctl     ctl;
    logic [63:0]   ld_base, ld_len;
    logic [31:0]   ld_type;

    logic [63:0] c_base [MAX_ENTRIES];
    logic [63:0] c_len  [MAX_ENTRIES];
    logic [31:0] c_type [MAX_ENTRIES];
    logic        c_swap [MAX_ENTRIES];
    logic        c_cv   [MAX_ENTRIES];
    logic [63:0] c_cval [MAX_ENTRIES];

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign full       = (r_count == CW'(MAX_ENTRIES));
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_kind == K_CARVE) begin
            ld_base = r_ep;
            ld_len  = c_cval[MAX_ENTRIES-1] - r_ep;
            ld_type = TYPE_RAM;
        end else begin
            ld_base = r_ldb;
            ld_len  = r_ldl;
            ld_type = r_ldt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_count      = r_count;
        n_res_addr   = r_res_addr;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        ctl          = '0;
        ctl.mode_find = (r_kind == K_FIND);
        ctl.parity    = r_step[0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_addr   = '1;
                    n_res_found  = 1'b0;
                    n_res_status = 1'b0;
                    n_step       = '0;
                    unique case (t_kind'(i_kind))
                        K_ADD: begin
                            if (full) begin
                                n_res_status = 1'b1;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_APPLY;
                            end
                        end
                        K_CARVE, K_FIND: n_state = S_SCAN;
                        K_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                n_step = r_step + SW'(1);
                if (r_step == SW'(MAX_ENTRIES + 3)) begin
                    n_step = '0;
                    if (r_kind == K_FIND) begin
                        n_res_found = c_cv[MAX_ENTRIES-1];
                        n_res_addr  = c_cv[MAX_ENTRIES-1] ? c_cval[MAX_ENTRIES-1] : '1;
                        n_state     = S_DONE;
                    end else if (c_cv[MAX_ENTRIES-1] && full) begin
                        n_res_status = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                ctl.apply = (r_kind == K_CARVE);
                ctl.load  = (r_kind == K_ADD) || c_cv[MAX_ENTRIES-1];
                if (ctl.load) begin
                    n_count = r_count + CW'(1);
                end
                n_step  = '0;
                n_state = S_SORT;
            end
            S_SORT: begin
                ctl.sort_en = 1'b1;
                n_step      = r_step + SW'(1);
                if (r_step == SW'(MAX_ENTRIES - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_addr   <= n_res_addr;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_lo_rsz     <= r_lo + {32'd0, r_rsz};
        if (accept) begin
            r_kind <= t_kind'(i_kind);
            r_sp   <= i_range_start;
            r_ep   <= i_range_end;
            r_lo   <= i_window_low;
            r_rlo  <= (i_window_low + PMASK) & ~PMASK;
            r_rhi  <= i_window_high & ~PMASK;
            r_rsz  <= 32'(({32'd0, i_request_size} + PMASK) & ~PMASK);
            r_ldb  <= i_entry_base;
            r_ldl  <= i_entry_length;
            r_ldt  <= i_entry_type;
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_addr   <= r_res_addr;
            r_out_found  <= r_res_found;
            r_out_status <= r_res_status;
            r_out_total  <= 6'(r_count);
        end
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [63:0] up_base, up_len, dn_base, dn_len, dn_cval;
        logic [31:0] up_type, dn_type;
        logic        dn_swap, dn_cv;
        if (g < MAX_ENTRIES - 1) begin : g_up
            assign up_base = c_base[g+1];
            assign up_len  = c_len[g+1];
            assign up_type = c_type[g+1];
        end else begin : g_top
            assign up_base = '0;
            assign up_len  = '0;
            assign up_type = '0;
        end
        if (g > 0) begin : g_dn
            assign dn_base = c_base[g-1];
            assign dn_len  = c_len[g-1];
            assign dn_type = c_type[g-1];
            assign dn_swap = c_swap[g-1];
            assign dn_cv   = c_cv[g-1];
            assign dn_cval = c_cval[g-1];
        end else begin : g_bot
            assign dn_base = '0;
            assign dn_len  = '0;
            assign dn_type = '0;
            assign dn_swap = 1'b0;
            assign dn_cv   = 1'b0;
            assign dn_cval = '0;
        end
        mmrt_cell #(
            .IDX        (g),
            .CW         (CW),
            .PAGE_SHIFT (PAGE_SHIFT)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_count   (r_count),
            .i_sp      (r_sp),
            .i_ep      (r_ep),
            .i_lo      (r_lo),
            .i_rlo     (r_rlo),
            .i_rhi     (r_rhi),
            .i_lo_rsz  (r_lo_rsz),
            .i_rsz     (r_rsz),
            .i_ld_base (ld_base),
            .i_ld_len  (ld_len),
            .i_ld_type (ld_type),
            .i_up_base (up_base),
            .i_up_len  (up_len),
            .i_up_type (up_type),
            .i_dn_base (dn_base),
            .i_dn_len  (dn_len),
            .i_dn_type (dn_type),
            .i_dn_swap (dn_swap),
            .i_dn_cv   (dn_cv),
            .i_dn_cval (dn_cval),
            .o_base    (c_base[g]),
            .o_len     (c_len[g]),
            .o_type    (c_type[g]),
            .o_swap    (c_swap[g]),
            .o_cv      (c_cv[g]),
            .o_cval    (c_cval[g])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_found_addr  = r_out_addr;
    assign o_found       = r_out_found;
    assign o_entry_total = r_out_total;
    assign o_status      = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_scan_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("entry count moved during scan");

    a_miss_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_found_addr == '1))
        else $error("address not all ones without a find hit");

    a_full_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_status && o_found))
        else $error("full status together with a find hit");
`endif

endmodule
